### hdl/lkv_pkg.sv
// shared types and constants for the lru key/value cache
package lkv_pkg;

  localparam int KEY_W       = 64;
  localparam int VAL_W       = 64;
  localparam int CAP_W       = 5;
  localparam int OCC_W       = 5;
  localparam int ENTRIES_DEF = 16;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // operation codes
  localparam logic ACT_GET = 1'b0;
  localparam logic ACT_PUT = 1'b1;

  typedef struct packed {
    logic             action;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } lkv_in_t;

  typedef struct packed {
    logic             hit;
    logic [VAL_W-1:0] value_res;
    logic [OCC_W-1:0] occupancy;
  } lkv_out_t;

endpackage

### hdl/lkv_lookup.sv
// parallel key compare across all entries
module lkv_lookup
  import lkv_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic               entry_valid [ENTRIES],
  input  logic [KEY_W-1:0]   entry_key   [ENTRIES],
  input  logic [KEY_W-1:0]   probe_key,
  output logic [ENTRIES-1:0] match
);

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match[i] = entry_valid[i] && (entry_key[i] == probe_key);
    end
  end

endmodule

### hdl/lkv_store.sv
// entry storage, recency ranks and the per-item update
module lkv_store
  import lkv_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               req_vld,
  input  lkv_in_t            req,
  input  logic [ENTRIES-1:0] match,
  input  logic [CAP_W-1:0]   capacity,
  output logic               entry_valid [ENTRIES],
  output logic [KEY_W-1:0]   entry_key   [ENTRIES],
  output lkv_out_t           res
);

  localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W  = $clog2(ENTRIES + 1);
  localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  logic [ENTRIES-1:0] valid_r, valid_nxt;
  logic [KEY_W-1:0]   key_r   [ENTRIES];
  logic [KEY_W-1:0]   key_nxt [ENTRIES];
  logic [VAL_W-1:0]   val_r   [ENTRIES];
  logic [VAL_W-1:0]   val_nxt [ENTRIES];
  logic [RANK_W-1:0]  rank_r  [ENTRIES];
  logic [RANK_W-1:0]  rank_nxt[ENTRIES];
  logic [CNT_W-1:0]   count_r, count_nxt;

  logic               hit, is_put, evict, insert;
  logic [VAL_W-1:0]   hit_val;
  logic [RANK_W-1:0]  hit_rank;
  logic [CMP_W-1:0]   cap_ext, cap_eff;
  logic [CNT_W-1:0]   cnt_m1;
  logic [ENTRIES-1:0] victim, valid_post, free_vec, slot;

  // capacity clamped to 1..ENTRIES
  always_comb begin
    cap_ext = CMP_W'(capacity);
    if (cap_ext == '0) begin
      cap_eff = CMP_W'(1);
    end else if (cap_ext > CMP_W'(ENTRIES)) begin
      cap_eff = CMP_W'(ENTRIES);
    end else begin
      cap_eff = cap_ext;
    end
  end

  // match is one-hot or zero, so an or of masked entries selects
  always_comb begin
    hit_val  = '0;
    hit_rank = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_val  = hit_val  | (match[i] ? val_r[i]  : '0);
      hit_rank = hit_rank | (match[i] ? rank_r[i] : '0);
    end
  end

  assign hit    = |match;
  assign is_put = (req.action == ACT_PUT);
  assign insert = !hit && is_put;
  assign evict  = insert && (CMP_W'(count_r) >= cap_eff);
  assign cnt_m1 = count_r - CNT_W'(1);

  // ranks are distinct 0..count-1, so the oldest holds count-1
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      victim[i] = valid_r[i] && (CNT_W'(rank_r[i]) == cnt_m1);
    end
  end

  assign valid_post = valid_r & ~(evict ? victim : '0);
  assign free_vec   = ~valid_post;
  assign slot       = free_vec & (~free_vec + ENTRIES'(1));

  always_comb begin
    valid_nxt = valid_r;
    count_nxt = count_r;
    for (int i = 0; i < ENTRIES; i++) begin
      key_nxt[i]  = key_r[i];
      val_nxt[i]  = val_r[i];
      rank_nxt[i] = rank_r[i];
    end
    if (req_vld) begin
      if (hit) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (match[i]) begin
            rank_nxt[i] = '0;
            if (is_put) begin
              val_nxt[i] = req.value;
            end
          end else if (valid_r[i] && (rank_r[i] < hit_rank)) begin
            rank_nxt[i] = rank_r[i] + RANK_W'(1);
          end
        end
      end else if (is_put) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (slot[i]) begin
            key_nxt[i]  = req.key;
            val_nxt[i]  = req.value;
            rank_nxt[i] = '0;
          end else if (valid_post[i]) begin
            rank_nxt[i] = rank_r[i] + RANK_W'(1);
          end
        end
        valid_nxt = valid_post | slot;
        count_nxt = (evict ? count_r : count_r + CNT_W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      count_r <= '0;
    end else begin
      valid_r <= valid_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < ENTRIES; i++) begin
      key_r[i]  <= key_nxt[i];
      val_r[i]  <= val_nxt[i];
      rank_r[i] <= rank_nxt[i];
    end
  end

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      entry_valid[i] = valid_r[i];
      entry_key[i]   = key_r[i];
    end
  end

  logic [CMP_W-1:0] occ_ext;
  assign occ_ext = CMP_W'(count_nxt);

  always_comb begin
    res.hit       = hit;
    res.value_res = (hit && !is_put) ? hit_val : '0;
    res.occupancy = occ_ext[OCC_W-1:0];
  end

endmodule

### hdl/lru_key_value_cache_core.sv
// top level of the fully associative lru key/value cache
//
//   channel  ports                          direction  handshake
//   -------  -----------------------------  ---------  ------------------------------
//   request  start, busy, in_item           in         taken when start && !busy
//   result   out_valid, out_item            out        one-cycle strobe, no back-pressure
//   config   cfg_we, cfg_wdata              in         capacity written when cfg_we
//
// one item per cycle, sustained; busy is never raised
// each item passes the request register, then compare/update and the result register
// all state for an item is written as it leaves the request register, so the next item
// behind it in that register already sees it
// synchronous active-low reset clears the valid bits, the count and the strobes
// the receiver cannot stall; every result is shown for exactly one cycle
module lru_key_value_cache_core
  import lkv_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  // request channel
  input  logic             start,
  output logic             busy,
  input  lkv_in_t          in_item,
  // result channel
  output logic             out_valid,
  output lkv_out_t         out_item,
  // capacity register
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_wdata
);

  // request register
  logic     req_vld_r;
  lkv_in_t  req_r;

  // result register
  logic     out_vld_r;
  lkv_out_t out_r;

  // capacity register, clamped later in the store
  logic [CAP_W-1:0] cap_r;

  logic               entry_valid [ENTRIES];
  logic [KEY_W-1:0]   entry_key   [ENTRIES];
  logic [ENTRIES-1:0] match;
  lkv_out_t           res;

  // the whole update is done between the request and result registers, so the request side never waits
  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
      cap_r     <= CAP_RESET;
    end else begin
      req_vld_r <= start && !busy;
      out_vld_r <= req_vld_r;
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
    end
  end

  // payload registers need no reset
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req_r <= in_item;
    end
    out_r <= res;
  end

  // compare the request key against every stored key at once
  lkv_lookup #(
    .ENTRIES (ENTRIES)
  ) u_lookup (
    .entry_valid (entry_valid),
    .entry_key   (entry_key),
    .probe_key   (req_r.key),
    .match       (match)
  );

  // hit/miss handling, eviction of the oldest entry and rank aging
  lkv_store #(
    .ENTRIES (ENTRIES)
  ) u_store (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_vld     (req_vld_r),
    .req         (req_r),
    .match       (match),
    .capacity    (cap_r),
    .entry_valid (entry_valid),
    .entry_key   (entry_key),
    .res         (res)
  );

  assign out_valid = out_vld_r;
  assign out_item  = out_r;

endmodule
